// File: rtl/core/xor_checked_frame_receiver_core_defines.svh
// Assertion macros shared by the frame receiver modules.
// Depends on nothing; users must have ports named clock and reset.
`ifndef XOR_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define XOR_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define XCFR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("frame receiver check failed");
`define XCFR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame receiver check failed");
`define XCFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame receiver check failed");
`else
`define XCFR_ASSERT_ALWAYS(label, cond)
`define XCFR_ASSERT_IMP(label, ante, cons)
`define XCFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/xcfr_pkg.sv
// Shared types and constants of the frame receiver.
// Used by the controller, the datapath and the top level.
package xcfr_pkg;

   localparam int BYTE_W = 8;
   localparam int BUF_BYTES_DEF = 64;

   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type HEADER_RESET = 8'hBB;
   localparam byte_type MIN_LEN = 8'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_len;   // latch length, seed the check, clear the count
      logic take_byte;  // store a frame byte and fold it into the check
      logic rep_start;  // clear the count for replay
      logic rep_read;   // read the store at the count
      logic rep_load;   // move the read byte into the output register
      logic err_load;   // load a checksum-error result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hdr_hit;    // incoming byte equals the header value
      logic len_ok;     // incoming byte is a usable length
      logic frame_end;  // incoming byte is the check byte
      logic check_ok;   // incoming byte equals the running check
      logic out_free;   // output register can take a result this cycle
      logic rep_last;   // replay index points at the last stored byte
   } sts_type;

endpackage

// File: rtl/core/xor_checked_frame_receiver_core.sv
// Length-prefixed frame receiver with XOR check.
// Input bytes arrive on req_valid/req_ready/req_rx_byte, one byte per transfer.
// The block hunts for the header byte (csr_header_value, 0xBB after reset),
// then takes a length L counting command, payload and check byte. A length
// below 2 or above BUF_BYTES-2 silently restarts the hunt.
// Results leave on rsp_valid/rsp_ready with rsp_data_byte, rsp_status and
// rsp_is_last. A good frame replays its L-1 stored bytes, the last marked;
// a bad check gives one result with status 1 and data 0.
// Throughput: one input byte per cycle while a frame is collected. The check
// byte is taken once the output register is free; each replayed byte is first
// read through the registered read port of the frame store and then moved into
// the output register, waiting while that register is full. An error result
// shows in the cycle after the check byte. Input is held off during replay.
// If the receiver stalls, the result holds in the output register and the
// replay waits; the block keeps taking bytes while a final result waits.
// Reset is synchronous: it returns to the hunt, empties the output register
// and restores the header value. The store needs no clearing pass.
// csr_valid/csr_ready writes the header value; csr_ready is always high.
// Depends on xcfr_pkg, xcfr_ctrl and xcfr_dpath.
module xor_checked_frame_receiver_core #(
   parameter int BUF_BYTES = xcfr_pkg::BUF_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  xcfr_pkg::byte_type req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output xcfr_pkg::byte_type rsp_data_byte,
   output logic               rsp_status,
   output logic               rsp_is_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  xcfr_pkg::byte_type csr_header_value
);

   xcfr_pkg::cmd_type cmd;
   xcfr_pkg::sts_type sts;

   // Sequencing of hunt, length, data and replay.
   xcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, check and output register.
   xcfr_dpath #(
      .BUF_BYTES (BUF_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_status       (rsp_status),
      .rsp_is_last      (rsp_is_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_header_value (csr_header_value),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// File: rtl/core/xcfr_dpath.sv
// Datapath of the frame receiver: header register, frame store, running
// check, counters and output register. Depends on xcfr_pkg.
`include "xor_checked_frame_receiver_core_defines.svh"

module xcfr_dpath #(
   parameter int BUF_BYTES = xcfr_pkg::BUF_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  xcfr_pkg::byte_type req_rx_byte,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output xcfr_pkg::byte_type rsp_data_byte,
   output logic               rsp_status,
   output logic               rsp_is_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  xcfr_pkg::byte_type csr_header_value,
   input  xcfr_pkg::cmd_type  cmd,
   output xcfr_pkg::sts_type  sts
);

   localparam int AW = $clog2(BUF_BYTES);
   localparam xcfr_pkg::byte_type MAX_LEN = 8'(BUF_BYTES - 2);

   xcfr_pkg::byte_type header_ff, header_in;
   xcfr_pkg::byte_type len_ff, len_in;
   xcfr_pkg::byte_type cnt_ff, cnt_in;
   xcfr_pkg::byte_type chk_ff, chk_in;
   xcfr_pkg::byte_type rd_data_ff;
   xcfr_pkg::byte_type out_data_ff, out_data_in;
   logic               out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;
   logic               out_valid_ff, out_valid_in;
   xcfr_pkg::byte_type store_mem [BUF_BYTES];

   // The header register takes a write in any cycle.
   assign csr_ready = 1'b1;
   assign header_in = (csr_valid && csr_ready) ? csr_header_value : header_ff;

   // Length, count and running check.
   always_comb begin
      len_in = cmd.take_len ? req_rx_byte : len_ff;

      priority if (cmd.take_len || cmd.rep_start) begin
         cnt_in = '0;
      end else if (cmd.take_byte || cmd.rep_load) begin
         cnt_in = cnt_ff + 8'd1;
      end else begin
         cnt_in = cnt_ff;
      end

      priority if (cmd.take_len) begin
         chk_in = req_rx_byte;
      end else if (cmd.take_byte) begin
         chk_in = chk_ff ^ req_rx_byte;
      end else begin
         chk_in = chk_ff;
      end
   end

   // Output register: loaded with a result, emptied by a transfer.
   always_comb begin
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff;
      priority if (cmd.err_load) begin
         out_data_in   = '0;
         out_status_in = 1'b1;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
      end else if (cmd.rep_load) begin
         out_data_in   = rd_data_ff;
         out_status_in = 1'b0;
         out_last_in   = sts.rep_last;
         out_valid_in  = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in  = 1'b0;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.hdr_hit   = (req_rx_byte == header_ff);
      sts.len_ok    = (req_rx_byte >= xcfr_pkg::MIN_LEN) && (req_rx_byte <= MAX_LEN);
      sts.frame_end = ((cnt_ff + 8'd1) == len_ff);
      sts.check_ok  = (req_rx_byte == chk_ff);
      sts.out_free  = !out_valid_ff || rsp_ready;
      sts.rep_last  = ((cnt_ff + 8'd2) == len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= xcfr_pkg::HEADER_RESET;
         len_ff       <= '0;
         cnt_ff       <= '0;
         chk_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         chk_ff       <= chk_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // Frame store: one write port, one registered read port, both at the count.
   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         store_mem[cnt_ff[AW-1:0]] <= req_rx_byte;
      end
      if (cmd.rep_read) begin
         rd_data_ff <= store_mem[cnt_ff[AW-1:0]];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_is_last   = out_last_ff;

   // Stores stay inside the frame, and a pending result is never overwritten.
   `XCFR_ASSERT_IMP(a_store_in_frame, cmd.take_byte, (cnt_ff + 8'd1) < len_ff)
   `XCFR_ASSERT_IMP(a_no_overwrite, cmd.err_load || cmd.rep_load, sts.out_free)

endmodule

// File: rtl/core/xcfr_ctrl.sv
// Controller of the frame receiver: hunt, length, data and replay sequencing.
// Depends on xcfr_pkg; drives the datapath by command signals only.
`include "xor_checked_frame_receiver_core_defines.svh"

module xcfr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xcfr_pkg::sts_type sts,
   output xcfr_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LEN,
      ST_DATA,
      ST_REP_RD,
      ST_REP_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] cmd_vec;

   // Next state, input readiness and datapath commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_HUNT: begin
            req_ready = 1'b1;
            if (req_valid && sts.hdr_hit) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_len = sts.len_ok;
               state_in     = sts.len_ok ? ST_DATA : ST_HUNT;
            end
         end
         ST_DATA: begin
            // The check byte waits until the output register can take a result.
            req_ready = !sts.frame_end || sts.out_free;
            if (req_valid && req_ready) begin
               priority if (!sts.frame_end) begin
                  cmd.take_byte = 1'b1;
               end else if (sts.check_ok) begin
                  cmd.rep_start = 1'b1;
                  state_in      = ST_REP_RD;
               end else begin
                  cmd.err_load  = 1'b1;
                  state_in      = ST_HUNT;
               end
            end
         end
         ST_REP_RD: begin
            cmd.rep_read = 1'b1;
            state_in     = ST_REP_OUT;
         end
         ST_REP_OUT: begin
            if (sts.out_free) begin
               cmd.rep_load = 1'b1;
               state_in     = sts.rep_last ? ST_HUNT : ST_REP_RD;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd_vec = {cmd.take_len, cmd.take_byte, cmd.rep_start,
                     cmd.rep_read, cmd.rep_load, cmd.err_load};

   // One command at a time; replay blocks input and ends back in the hunt.
   `XCFR_ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd_vec))
   `XCFR_ASSERT_IMP(a_replay_blocks_input, state_ff == ST_REP_RD || state_ff == ST_REP_OUT, !req_ready)
   `XCFR_ASSERT_NEXT(a_last_to_hunt, cmd.rep_load && sts.rep_last, state_ff == ST_HUNT)

endmodule
